// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JSAI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JSAI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jsai_pkg.sv =====
package jsai_pkg;

    // Channel codes
    localparam logic [1:0] JSAI_CH_LADDER = 2'd0;
    localparam logic [1:0] JSAI_CH_UP     = 2'd1;
    localparam logic [1:0] JSAI_CH_INV    = 2'd2;
    localparam logic [1:0] JSAI_CH_FINE   = 2'd3;

    // Graded step thresholds
    localparam logic [11:0] JSAI_UP0      = 12'd2500;
    localparam logic [11:0] JSAI_UP0_FINE = 12'd2400;
    localparam logic [11:0] JSAI_UP1      = 12'd3000;
    localparam logic [11:0] JSAI_UP2      = 12'd3600;
    localparam logic [11:0] JSAI_UP3      = 12'd4000;
    localparam logic [11:0] JSAI_DN0      = 12'd1500;
    localparam logic [11:0] JSAI_DN0_FINE = 12'd1600;
    localparam logic [11:0] JSAI_DN1      = 12'd1000;
    localparam logic [11:0] JSAI_DN2      = 12'd400;
    localparam logic [11:0] JSAI_DN3      = 12'd100;

    // Absolute ladder thresholds
    localparam logic [11:0] JSAI_LAD_T0 = 12'd150;
    localparam logic [11:0] JSAI_LAD_T1 = 12'd400;
    localparam logic [11:0] JSAI_LAD_T2 = 12'd1000;
    localparam logic [11:0] JSAI_LAD_T3 = 12'd1500;
    localparam logic [11:0] JSAI_LAD_T4 = 12'd2500;
    localparam logic [11:0] JSAI_LAD_T5 = 12'd3000;
    localparam logic [11:0] JSAI_LAD_T6 = 12'd3600;
    localparam logic [11:0] JSAI_LAD_T7 = 12'd3950;

    // Absolute ladder angles
    localparam logic [10:0] JSAI_LAD_A0 = 11'd1200;
    localparam logic [10:0] JSAI_LAD_A1 = 11'd1050;
    localparam logic [10:0] JSAI_LAD_A2 = 11'd1000;
    localparam logic [10:0] JSAI_LAD_A3 = 11'd950;
    localparam logic [10:0] JSAI_LAD_A4 = 11'd900;
    localparam logic [10:0] JSAI_LAD_A5 = 11'd850;
    localparam logic [10:0] JSAI_LAD_A6 = 11'd800;
    localparam logic [10:0] JSAI_LAD_A7 = 11'd750;
    localparam logic [10:0] JSAI_LAD_A8 = 11'd600;

    // Clamp limits
    localparam logic [10:0] JSAI_UP_MIN   = 11'd100;
    localparam logic [10:0] JSAI_INV_MIN  = 11'd400;
    localparam logic [10:0] JSAI_MAX      = 11'd1800;
    localparam logic [10:0] JSAI_FINE_MAX = 11'd300;

    // compare = floor(angle * 1111 / 1000) + 500
    // 1.111 as ceil(1.111 * 2^24); exact for every 11-bit angle.
    localparam int          JSAI_CMP_SHIFT  = 24;
    localparam logic [24:0] JSAI_CMP_MULT   = 25'd18639487;
    localparam logic [11:0] JSAI_CMP_OFFSET = 12'd500;

    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] adc_sample;
    } t_jsai_in_req;

    typedef struct packed {
        logic [1:0]  channel_echo;
        logic [10:0] angle;
        logic [11:0] compare_value;
    } t_jsai_out_req;

endpackage

// ===== hw/rtl/joystick_servo_angle_integrator_top.sv =====
// A request passes through the input reg, angle reg and out reg in that order.
// Throughput: one request per cycle without output stall; read-modify-write is one stage.
// The PWM compare is a single 11x25 constant multiply in the last stage.
// Reset (sync, active low) zeroes all four channel angles and empties the pipe.
module joystick_servo_angle_integrator_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  jsai_pkg::t_jsai_in_req  i_in_req,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output jsai_pkg::t_jsai_out_req o_out_req
);
    import jsai_pkg::*;

`include "assert_macros.svh"

    // Stage valids and payloads
    logic          r_in_v;
    t_jsai_in_req  r_in;
    logic          r_mid_v;
    logic [1:0]    r_mid_ch;
    logic [10:0]   r_mid_angle;
    logic          r_out_v;
    t_jsai_out_req r_out;

    // Per-channel angle store, four 11-bit registers, cleared by reset
    logic [10:0]   r_store [4];

    // Backpressure: each stage moves when the one after it is empty or moving,
    // so bubbles collapse and requests fill empty stages while a result waits.
    logic w_out_rdy;
    logic w_mid_rdy;
    logic w_in_rdy;
    logic w_mid_load;

    assign w_out_rdy  = !r_out_v || !i_out_stall;
    assign w_mid_rdy  = !r_mid_v || w_out_rdy;
    assign w_in_rdy   = !r_in_v || w_mid_rdy;
    assign w_mid_load = r_in_v && w_mid_rdy;

    assign o_in_stall  = !w_in_rdy;
    assign o_out_valid = r_out_v;
    assign o_out_req   = r_out;

    // ---------------------------------------------------------------
    // Angle update (from input register to angle register)
    // ---------------------------------------------------------------
    logic [11:0]        w_v;
    logic [10:0]        w_old;
    logic               w_fine;
    logic [3:0]         w_up;
    logic [3:0]         w_dn;
    logic signed [5:0]  w_step;
    logic signed [12:0] w_sum;
    logic               w_neg;
    logic [11:0]        w_mag;
    logic [10:0]        w_ladder;
    logic [10:0]        n_angle;

    assign w_v    = r_in.adc_sample;
    assign w_old  = r_store[r_in.channel];
    assign w_fine = (r_in.channel == JSAI_CH_FINE);

    // Nested thresholds: the bit pattern is the step size (0, 1, 3, 7, 15).
    assign w_up[0] = w_v >= (w_fine ? JSAI_UP0_FINE : JSAI_UP0);
    assign w_up[1] = w_v >= JSAI_UP1;
    assign w_up[2] = w_v >= JSAI_UP2;
    assign w_up[3] = w_v >= JSAI_UP3;
    assign w_dn[0] = w_v <= (w_fine ? JSAI_DN0_FINE : JSAI_DN0);
    assign w_dn[1] = w_v <= JSAI_DN1;
    assign w_dn[2] = w_v <= JSAI_DN2;
    assign w_dn[3] = w_v <= JSAI_DN3;

    // Channel 2 runs the opposite way
    always_comb begin
        if (r_in.channel == JSAI_CH_INV) begin
            w_step = $signed({2'b00, w_dn}) - $signed({2'b00, w_up});
        end else begin
            w_step = $signed({2'b00, w_up}) - $signed({2'b00, w_dn});
        end
    end

    assign w_sum = $signed({2'b00, w_old}) + 13'(w_step);
    assign w_neg = w_sum[12];
    assign w_mag = w_sum[11:0];

    // Absolute ladder for channel 0; first match wins
    always_comb begin
        priority if (w_v <= JSAI_LAD_T0) begin
            w_ladder = JSAI_LAD_A0;
        end else if (w_v <= JSAI_LAD_T1) begin
            w_ladder = JSAI_LAD_A1;
        end else if (w_v <= JSAI_LAD_T2) begin
            w_ladder = JSAI_LAD_A2;
        end else if (w_v <= JSAI_LAD_T3) begin
            w_ladder = JSAI_LAD_A3;
        end else if (w_v <= JSAI_LAD_T4) begin
            w_ladder = JSAI_LAD_A4;
        end else if (w_v < JSAI_LAD_T5) begin
            w_ladder = JSAI_LAD_A5;
        end else if (w_v < JSAI_LAD_T6) begin
            w_ladder = JSAI_LAD_A6;
        end else if (w_v < JSAI_LAD_T7) begin
            w_ladder = JSAI_LAD_A7;
        end else begin
            w_ladder = JSAI_LAD_A8;
        end
    end

    // Clamp. A negative sum on channels 1/2 would wrap past the top limit,
    // so it pins high; on channel 3 it pins to zero.
    always_comb begin
        unique case (r_in.channel)
            JSAI_CH_LADDER: begin
                n_angle = w_ladder;
            end
            JSAI_CH_UP: begin
                if (w_neg || w_mag >= {1'b0, JSAI_MAX}) begin
                    n_angle = JSAI_MAX;
                end else if (w_mag <= {1'b0, JSAI_UP_MIN}) begin
                    n_angle = JSAI_UP_MIN;
                end else begin
                    n_angle = w_mag[10:0];
                end
            end
            JSAI_CH_INV: begin
                if (w_neg || w_mag >= {1'b0, JSAI_MAX}) begin
                    n_angle = JSAI_MAX;
                end else if (w_mag <= {1'b0, JSAI_INV_MIN}) begin
                    n_angle = JSAI_INV_MIN;
                end else begin
                    n_angle = w_mag[10:0];
                end
            end
            JSAI_CH_FINE: begin
                if (w_neg) begin
                    n_angle = '0;
                end else if (w_mag >= {1'b0, JSAI_FINE_MAX}) begin
                    n_angle = JSAI_FINE_MAX;
                end else begin
                    n_angle = w_mag[10:0];
                end
            end
            default: begin
                n_angle = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // PWM compare (from angle register to output register)
    // ---------------------------------------------------------------
    logic [35:0]   w_prod;
    t_jsai_out_req n_out;

    assign w_prod = {25'd0, r_mid_angle} * {11'd0, JSAI_CMP_MULT};

    always_comb begin
        n_out.channel_echo  = r_mid_ch;
        n_out.angle         = r_mid_angle;
        n_out.compare_value = w_prod[JSAI_CMP_SHIFT +: 12] + JSAI_CMP_OFFSET;
    end

    // Control state and angle store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (w_in_rdy) begin
                r_in_v <= i_in_valid;
            end
            if (w_mid_rdy) begin
                r_mid_v <= r_in_v;
            end
            if (w_out_rdy) begin
                r_out_v <= r_mid_v;
            end
            // Write-back lands before the next request reads the store
            if (w_mid_load) begin
                r_store[r_in.channel] <= n_angle;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (w_mid_load) begin
            r_mid_ch    <= r_in.channel;
            r_mid_angle <= n_angle;
        end
        if (w_out_rdy && r_mid_v) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `JSAI_ASSERT_NEXT(a_store_wb, w_mid_load, r_store[r_mid_ch] == r_mid_angle, "store write-back mismatch")
    `JSAI_ASSERT_NOW(a_full_stall, r_in_v && r_mid_v && r_out_v && i_out_stall, o_in_stall, "accept into full pipe")
    `JSAI_ASSERT_NOW(a_ch1_range, r_out_v && r_out.channel_echo == JSAI_CH_UP, r_out.angle >= JSAI_UP_MIN && r_out.angle <= JSAI_MAX, "channel 1 angle out of range")
    `JSAI_ASSERT_NOW(a_ch3_range, r_mid_v && r_mid_ch == JSAI_CH_FINE, r_mid_angle <= JSAI_FINE_MAX, "channel 3 angle out of range")

endmodule
